@@ src/hsv_to_rgb_converter_macros.svh @@
// Assertion macros shared by the HSV to RGB converter modules.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

// Check that the antecedent implies the consequent in the same cycle.
`define HSVRGB_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");

// Check that the antecedent implies the consequent in the next cycle.
`define HSVRGB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");

`else

`define HSVRGB_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define HSVRGB_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ src/hsvrgb_pkg.sv @@
// Types, constants and the hue fraction table of the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

  localparam int FracBits  = 12;
  localparam int One       = 1 << FracBits;
  localparam int UnitW     = FracBits + 1;
  localparam int ProdW     = 2 * UnitW;
  localparam int HueW      = 10;
  localparam int CompW     = 16;
  localparam int HueModW   = 9;
  localparam int RemW      = 6;
  localparam int HueCircle = 360;
  localparam int SectorDeg = 60;

  typedef enum logic [2:0] {
    SecRY = 3'd0,  // red to yellow
    SecYG = 3'd1,  // yellow to green
    SecGC = 3'd2,  // green to cyan
    SecCB = 3'd3,  // cyan to blue
    SecBM = 3'd4,  // blue to magenta
    SecMR = 3'd5   // magenta to red
  } sector_e;

  typedef struct packed {
    logic        [HueW-1:0]  hue_deg;
    logic signed [CompW-1:0] saturation;
    logic signed [CompW-1:0] brightness;
  } hsv_req_t;

  typedef struct packed {
    logic [UnitW-1:0] red;
    logic [UnitW-1:0] green;
    logic [UnitW-1:0] blue;
  } rgb_rsp_t;

  // Hue split: sector, fraction and its complement, clamped S and V.
  typedef struct packed {
    sector_e          sector;
    logic [UnitW-1:0] frac;
    logic [UnitW-1:0] frac_c;
    logic [UnitW-1:0] sat;
    logic [UnitW-1:0] val;
  } split_t;

  // Products ready for channel routing.
  typedef struct packed {
    sector_e          sector;
    logic [UnitW-1:0] val;
    logic [UnitW-1:0] p1;
    logic [UnitW-1:0] p2;
    logic [UnitW-1:0] p3;
  } prod_t;

  typedef logic [FracBits-1:0] frac_tab_t [SectorDeg];

  // (rem * One) / 60, truncated, for every remainder within a sector.
  function automatic frac_tab_t build_frac_tab();
    frac_tab_t tab;
    for (int i = 0; i < SectorDeg; i++) begin
      tab[i] = FracBits'((i * One) / SectorDeg);
    end
    return tab;
  endfunction

  localparam frac_tab_t FracTab = build_frac_tab();

endpackage

`default_nettype wire

@@ src/hsvrgb_split.sv @@
// Clamp, hue reduction and sector/fraction split: three register stages.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

module hsvrgb_split (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire hsvrgb_pkg::hsv_req_t req_i,
  output logic                    valid_o,
  output hsvrgb_pkg::split_t      split_o
);
  import hsvrgb_pkg::*;

  logic                 v1_q, v2_q, v3_q;
  logic [HueModW-1:0]   hue1_d, hue1_q;
  logic [UnitW-1:0]     sat1_d, sat1_q, val1_d, val1_q;
  sector_e              sec2_d, sec2_q;
  logic [RemW-1:0]      rem2_d, rem2_q;
  logic [HueModW-1:0]   base2;
  logic [UnitW-1:0]     sat2_q, val2_q;
  split_t               split3_d, split3_q;

  function automatic logic [UnitW-1:0] clamp_unit(input logic signed [CompW-1:0] raw);
    logic [UnitW-1:0] res;
    if (raw < 0) begin
      res = '0;
    end else if (raw > CompW'(One)) begin
      res = UnitW'(One);
    end else begin
      res = raw[UnitW-1:0];
    end
    return res;
  endfunction

  // Stage 1: clamp S and V, reduce hue modulo 360 (input stays below three turns)
  always_comb begin
    sat1_d = clamp_unit(req_i.saturation);
    val1_d = clamp_unit(req_i.brightness);
    if (req_i.hue_deg >= HueW'(2 * HueCircle)) begin
      hue1_d = HueModW'(req_i.hue_deg - HueW'(2 * HueCircle));
    end else if (req_i.hue_deg >= HueW'(HueCircle)) begin
      hue1_d = HueModW'(req_i.hue_deg - HueW'(HueCircle));
    end else begin
      hue1_d = req_i.hue_deg[HueModW-1:0];
    end
  end

  // Stage 2: sector by compare, remainder by subtracting the sector base
  always_comb begin
    if (hue1_q >= HueModW'(5 * SectorDeg)) begin
      sec2_d = SecMR;
      base2  = HueModW'(5 * SectorDeg);
    end else if (hue1_q >= HueModW'(4 * SectorDeg)) begin
      sec2_d = SecBM;
      base2  = HueModW'(4 * SectorDeg);
    end else if (hue1_q >= HueModW'(3 * SectorDeg)) begin
      sec2_d = SecCB;
      base2  = HueModW'(3 * SectorDeg);
    end else if (hue1_q >= HueModW'(2 * SectorDeg)) begin
      sec2_d = SecGC;
      base2  = HueModW'(2 * SectorDeg);
    end else if (hue1_q >= HueModW'(SectorDeg)) begin
      sec2_d = SecYG;
      base2  = HueModW'(SectorDeg);
    end else begin
      sec2_d = SecRY;
      base2  = '0;
    end
    rem2_d = RemW'(hue1_q - base2);
  end

  // Stage 3: fraction from the table and its complement
  always_comb begin
    split3_d.sector = sec2_q;
    split3_d.frac   = {1'b0, FracTab[rem2_q]};
    split3_d.frac_c = UnitW'(One) - {1'b0, FracTab[rem2_q]};
    split3_d.sat    = sat2_q;
    split3_d.val    = val2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hue1_q   <= hue1_d;
    sat1_q   <= sat1_d;
    val1_q   <= val1_d;
    sec2_q   <= sec2_d;
    rem2_q   <= rem2_d;
    sat2_q   <= sat1_q;
    val2_q   <= val1_q;
    split3_q <= split3_d;
  end

  assign valid_o = v3_q;
  assign split_o = split3_q;

  `HSVRGB_ASSERT_IMPLIES(a_frac_sum, clk_i, rst_ni, v3_q,
    (UnitW+1)'(split3_q.frac) + (UnitW+1)'(split3_q.frac_c) == (UnitW+1)'(One))

endmodule

`default_nettype wire

@@ src/hsvrgb_mul.sv @@
// Product stages: S*f, S*(1-f) and V*(1-S), then V times the complements.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

module hsvrgb_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire hsvrgb_pkg::split_t split_i,
  output logic                    valid_o,
  output hsvrgb_pkg::prod_t       prod_o
);
  import hsvrgb_pkg::*;

  logic             v4_q, v5_q;
  sector_e          sec4_q;
  logic [UnitW-1:0] val4_q;
  logic [ProdW-1:0] sf_full, sfc_full, p1_full;
  logic [UnitW-1:0] sf_q, sfc_q, p1_q;
  logic [ProdW-1:0] p2_full, p3_full;
  prod_t            prod5_d, prod5_q;

  // Stage 4: three independent multiplies, truncated back to unit scale
  always_comb begin
    sf_full  = ProdW'(split_i.sat) * ProdW'(split_i.frac);
    sfc_full = ProdW'(split_i.sat) * ProdW'(split_i.frac_c);
    p1_full  = ProdW'(split_i.val) * ProdW'(UnitW'(One) - split_i.sat);
  end

  // Stage 5: V times (1 - S*f) and (1 - S*(1-f))
  always_comb begin
    p2_full = ProdW'(val4_q) * ProdW'(UnitW'(One) - sf_q);
    p3_full = ProdW'(val4_q) * ProdW'(UnitW'(One) - sfc_q);
    prod5_d.sector = sec4_q;
    prod5_d.val    = val4_q;
    prod5_d.p1     = p1_q;
    prod5_d.p2     = p2_full[FracBits+UnitW-1:FracBits];
    prod5_d.p3     = p3_full[FracBits+UnitW-1:FracBits];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sec4_q  <= split_i.sector;
    val4_q  <= split_i.val;
    sf_q    <= sf_full[FracBits+UnitW-1:FracBits];
    sfc_q   <= sfc_full[FracBits+UnitW-1:FracBits];
    p1_q    <= p1_full[FracBits+UnitW-1:FracBits];
    prod5_q <= prod5_d;
  end

  assign valid_o = v5_q;
  assign prod_o  = prod5_q;

  `HSVRGB_ASSERT_IMPLIES(a_prod_le_val, clk_i, rst_ni, v5_q,
    prod5_q.p1 <= prod5_q.val && prod5_q.p2 <= prod5_q.val && prod5_q.p3 <= prod5_q.val)

endmodule

`default_nettype wire

@@ src/hsvrgb_route.sv @@
// Channel routing by sector into the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

module hsvrgb_route (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire hsvrgb_pkg::prod_t prod_i,
  output logic                   valid_o,
  output hsvrgb_pkg::rgb_rsp_t   rsp_o
);
  import hsvrgb_pkg::*;

  logic     v6_q;
  rgb_rsp_t rsp_d, rsp_q;

  always_comb begin
    unique case (prod_i.sector)
      SecRY: begin
        rsp_d.red = prod_i.val; rsp_d.green = prod_i.p3;  rsp_d.blue = prod_i.p1;
      end
      SecYG: begin
        rsp_d.red = prod_i.p2;  rsp_d.green = prod_i.val; rsp_d.blue = prod_i.p1;
      end
      SecGC: begin
        rsp_d.red = prod_i.p1;  rsp_d.green = prod_i.val; rsp_d.blue = prod_i.p3;
      end
      SecCB: begin
        rsp_d.red = prod_i.p1;  rsp_d.green = prod_i.p2;  rsp_d.blue = prod_i.val;
      end
      SecBM: begin
        rsp_d.red = prod_i.p3;  rsp_d.green = prod_i.p1;  rsp_d.blue = prod_i.val;
      end
      default: begin
        rsp_d.red = prod_i.val; rsp_d.green = prod_i.p1;  rsp_d.blue = prod_i.p2;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = v6_q;
  assign rsp_o   = rsp_q;

  `HSVRGB_ASSERT_IMPLIES(a_rgb_range, clk_i, rst_ni, v6_q,
    rsp_q.red <= UnitW'(One) && rsp_q.green <= UnitW'(One) && rsp_q.blue <= UnitW'(One))

endmodule

`default_nettype wire

@@ src/hsv_to_rgb_converter.sv @@
// Top level of the pipelined HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

// One colour enters per clock: a request is taken on every cycle with start
// high, and busy stays low. Each result appears on rsp_o with done_o high for
// exactly one cycle, in request order; the receiver cannot stall, so it must
// take every result as it comes. The six register stages are: clamp and hue
// reduction, sector split, fraction table, first multiplies, second multiplies,
// channel routing. Throughput is one colour per cycle, set by the fully
// pipelined multiply stages.
module hsv_to_rgb_converter (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire hsvrgb_pkg::hsv_req_t req_i,
  output logic                      done_o,
  output hsvrgb_pkg::rgb_rsp_t      rsp_o
);
  import hsvrgb_pkg::*;

  logic     accept;
  logic     split_valid, prod_valid;
  split_t   split;
  prod_t    prod;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  hsvrgb_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .req_i   (req_i),
    .valid_o (split_valid),
    .split_o (split)
  );

  hsvrgb_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .split_i (split),
    .valid_o (prod_valid),
    .prod_o  (prod)
  );

  hsvrgb_route u_route (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .prod_i  (prod),
    .valid_o (done_o),
    .rsp_o   (rsp_o)
  );

  `HSVRGB_ASSERT_IMPLIES(a_latency, clk_i, rst_ni, accept, ##6 done_o)
  `HSVRGB_ASSERT_IMPLIES(a_no_spurious, clk_i, rst_ni, done_o, $past(accept, 6))

endmodule

`default_nettype wire
